[sv/two_bank_bitmap_index_allocator_unit_assert.svh]
// Assertion macros shared by the allocator checker.
// Include with the bare file name; no other dependencies.
`ifndef TWO_BANK_BITMAP_INDEX_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_BANK_BITMAP_INDEX_ALLOCATOR_UNIT_ASSERT_SVH

// Clocked assertion, disabled while reset is held low.
`define TBBA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Same check, always active, including during reset.
`define TBBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/tbba_pkg.sv]
// Shared types and constants of the two-bank bitmap index allocator.
// No dependencies.
package tbba_pkg;

    localparam int DEF_ENTRIES = 128;
    localparam int SLOT_W      = 8;
    localparam int GIVEN_W     = 7;
    localparam int COUNT_W     = 8;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic BANK_MAIN = 1'b0;
    localparam logic BANK_SUB  = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_FREED     = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    typedef struct packed {
        logic              op;
        logic              bank;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [GIVEN_W-1:0] given_index;
        logic [COUNT_W-1:0] used_count;
    } t_rsp;

endpackage

[sv/tbba_pick.sv]
// Highest-free-slot priority encoder over one bank's used bitmap.
// Depends on tbba_pkg.
module tbba_pick
    import tbba_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic [ENTRIES-1:0] i_used,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_idx
);

    // Ascending scan: the last free bit seen is the highest one.
    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!i_used[i]) begin
                o_found = 1'b1;
                o_idx   = IDX_W'(i);
            end
        end
    end

endmodule

[sv/tbba_bank.sv]
// One allocator bank: used bitmap, in-use count and the per-request response.
// Depends on tbba_pkg and tbba_pick.
module tbba_bank
    import tbba_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_req i_req,
    output t_rsp o_rsp
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (IDX_W + 1 > SLOT_W + 1) ? IDX_W + 1 : SLOT_W + 1;

    logic [ENTRIES-1:0] r_used;
    logic [ENTRIES-1:0] n_used;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    logic             found;
    logic [IDX_W-1:0] pick_idx;
    logic [IDX_W-1:0] slot_ix;
    logic             in_range;
    logic             hit;

    tbba_pick #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_pick (
        .i_used  (r_used),
        .o_found (found),
        .o_idx   (pick_idx)
    );

    assign in_range = CMP_W'(i_req.slot_index) < CMP_W'(ENTRIES);
    assign slot_ix  = IDX_W'(i_req.slot_index);
    assign hit      = in_range && r_used[slot_ix];

    always_comb begin
        n_used            = r_used;
        n_count           = r_count;
        o_rsp.given_index = '0;
        if (i_req.op == OP_ALLOC) begin
            if (found) begin
                n_used[pick_idx]  = 1'b1;
                n_count           = r_count + CNT_W'(1);
                o_rsp.given_index = GIVEN_W'(pick_idx);
                o_rsp.status      = ST_ALLOCATED;
            end else begin
                o_rsp.status = ST_FULL;
            end
        end else begin
            if (hit) begin
                n_used[slot_ix] = 1'b0;
                n_count         = r_count - CNT_W'(1);
                o_rsp.status    = ST_FREED;
            end else begin
                o_rsp.status = ST_IGNORED;
            end
        end
        o_rsp.used_count = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_used  <= n_used;
            r_count <= n_count;
        end
    end

endmodule

[sv/two_bank_bitmap_index_allocator_unit.sv]
// Top level of the two-bank bitmap index allocator.
// Depends on tbba_pkg, tbba_bank and tbba_pick.
//
// Each request (allocate highest free slot, or free a given slot, on the main
// or sub bank) is taken with start while busy is low and answered, via the
// request and result registers, by a one-cycle o_done beat carrying o_rsp.
// A new request can be taken every cycle: the request register feeds the
// priority encode and count update, and the result register holds the
// answer. busy is high only during reset and the first cycle after it. The
// receiver cannot stall, so o_done must be consumed in the cycle it is shown.
module two_bank_bitmap_index_allocator_unit
    import tbba_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    logic r_busy;
    logic r_req_vld;
    t_req r_req;
    logic r_done;
    t_rsp r_rsp;
    t_rsp n_rsp;
    t_rsp main_rsp;
    t_rsp sub_rsp;

    tbba_bank #(
        .ENTRIES (ENTRIES)
    ) u_main (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_req_vld && r_req.bank == BANK_MAIN),
        .i_req   (r_req),
        .o_rsp   (main_rsp)
    );

    tbba_bank #(
        .ENTRIES (ENTRIES)
    ) u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_req_vld && r_req.bank == BANK_SUB),
        .i_req   (r_req),
        .o_rsp   (sub_rsp)
    );

    assign n_rsp = (r_req.bank == BANK_SUB) ? sub_rsp : main_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b1;
            r_req_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_busy    <= 1'b0;
            r_req_vld <= start && !r_busy;
            r_done    <= r_req_vld;
        end
    end

    // Payload registers: load on each beat, no reset needed.
    always_ff @(posedge i_clk) begin
        if (start && !r_busy) begin
            r_req <= i_req;
        end
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign busy   = r_busy;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

[sv/tbba_checker.sv]
// Port-level checker for the allocator, bound to the top level.
// Depends on tbba_pkg and two_bank_bitmap_index_allocator_unit_assert.svh.
`include "two_bank_bitmap_index_allocator_unit_assert.svh"

module tbba_checker
    import tbba_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input t_rsp o_rsp
);

    `TBBA_ASSERT(a_beat_answered, i_clk, i_rst_n,
        (start && !busy) |=> ##1 o_done,
        "accepted request got no result")
    `TBBA_ASSERT(a_no_extra_result, i_clk, i_rst_n,
        o_done |-> $past(start && !busy, 2),
        "result without a request")
    `TBBA_ASSERT(a_given_zero, i_clk, i_rst_n,
        (o_done && o_rsp.status != ST_ALLOCATED) |-> (o_rsp.given_index == '0),
        "given_index nonzero without allocation")
    `TBBA_ASSERT_ALWAYS(a_reset_quiet, i_clk,
        !i_rst_n |=> (!o_done && busy),
        "result or ready right after reset")

endmodule

bind two_bank_bitmap_index_allocator_unit tbba_checker u_tbba_checker (.*);
